// ===== rtl/cmtn_pkg.sv =====
package cmtn_pkg;

	// Internal datapath width: holds every stage value without overflow.
	localparam int unsigned DW = 48;
	localparam int unsigned FRAC = 16;
	localparam int unsigned TBL_LEN = 12;

	localparam logic [DW-1:0] ONE_FIX = DW'(64'd1 << FRAC);
	localparam logic [DW-1:0] X0_FIX = DW'(64'd83263);

	localparam logic [1:0] ADDR_ITER = 2'd0;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LIN  = 6'b000010,
		ST_HYP  = 6'b000100,
		ST_DIVP = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	function automatic logic [DW-1:0] atanh_fix(input logic [3:0] idx);
		logic [DW-1:0] v;
		begin
			case (idx)
				4'd0: v = DW'(64'd35979);
				4'd1: v = DW'(64'd16712);
				4'd2: v = DW'(64'd8192);
				4'd3: v = DW'(64'd4063);
				4'd4: v = DW'(64'd2032);
				4'd5: v = DW'(64'd983);
				4'd6: v = DW'(64'd511);
				4'd7: v = DW'(64'd256);
				4'd8: v = DW'(64'd125);
				4'd9: v = DW'(64'd64);
				4'd10: v = DW'(64'd31);
				4'd11: v = DW'(64'd16);
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

// ===== rtl/cmtn_div.sv =====
module cmtn_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [cmtn_pkg::DW-1:0] num,
	input  logic [cmtn_pkg::DW-1:0] den,
	output logic                    done,
	output logic [16:0]             quot
);
	import cmtn_pkg::*;

	// Restoring division, one quotient bit a cycle; num < den on entry.
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [16:0]   quot_q;
	logic [4:0]    cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;

	assign trial = {rem_q[DW-1:0], 1'b0} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(FRAC - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			if (!trial[DW]) begin
				rem_q <= trial;
				quot_q <= {quot_q[15:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-1:0], 1'b0};
				quot_q <= {quot_q[15:0], 1'b0};
			end
		end
	end

	assign done = busy_q && (cnt_q == 5'(FRAC - 1));
	assign quot = done ? {quot_q[15:0], ~trial[DW]} : quot_q;
endmodule

// ===== rtl/cordic_mac_tanh_neuron.sv =====
// CORDIC neuron: tanh_out = tanh(bias + weight * activation_in); the inputs are
// signed Q16.16 and tanh_out is signed Q2.16. One item at a time runs through
// shift-add datapaths: a linear-mode CORDIC multiply-accumulate of n steps, a
// hyperbolic CORDIC of n steps (n = min(iterations, 12)), then a restoring
// division y/x producing one quotient bit per cycle. The work runs through the
// linear and hyperbolic step loops, a compare state, the division and a state
// that raises out_valid. A zero step count skips the linear loop but still
// passes through the hyperbolic state. A saturated or zero-divisor result
// skips the division. The input stalls from acceptance until the result is
// taken. The result is saturated to +/-1.0 and held in an output register
// until taken.
module cordic_mac_tanh_neuron (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] weight,
	input  logic signed [31:0] activation_in,
	input  logic signed [31:0] bias,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [17:0] tanh_out
);
	import cmtn_pkg::*;

	state_t        state_q;
	logic [3:0]    iter_q;
	logic [3:0]    step_q;
	logic [3:0]    nsteps;
	logic [DW-1:0] x_q, y_q, z_q;
	logic          neg_q;
	logic [17:0]   res_q;
	logic          out_valid_q;
	logic          div_start;
	logic          div_done;
	logic [16:0]   div_quot;
	logic [DW-1:0] ax, ay;
	logic [DW-1:0] xs, stp, tv;
	logic          zpos;
	logic          hyp_init_q;
	logic [DW-1:0] hx, hy, hz, hxs, hys;
	logic          hzpos;
	logic [DW-1:0] hx_q, hy_q, hz_q;

	assign pready = 1'b1;
	assign prdata = {28'd0, iter_q};

	// Register write: hold the step count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) iter_q <= 4'd12;
		else if (psel && penable && pwrite && paddr == ADDR_ITER) iter_q <= pwdata[3:0];
	end

	assign nsteps = (iter_q > 4'd12) ? 4'd12 : iter_q;
	assign in_stall = (state_q != ST_IDLE);
	assign zpos = !z_q[DW-1] && (z_q != '0);

	// Shifted operands for the current step.
	assign xs  = $signed(x_q) >>> step_q;
	assign stp = ONE_FIX >> step_q;
	assign tv  = atanh_fix(step_q);

	// Division operands come from the hyperbolic bank.
	assign ax = hx_q[DW-1] ? -hx_q : hx_q;
	assign ay = hy_q[DW-1] ? -hy_q : hy_q;
	assign div_start = (state_q == ST_DIVP) && (ay < ax);

	cmtn_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (ay),
		.den   (ax),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) begin
					step_q <= '0;
					state_q <= (nsteps == 4'd0) ? ST_HYP : ST_LIN;
				end
				ST_LIN: begin
					// Advance the linear steps.
					if (step_q == nsteps - 4'd1) begin
						step_q <= '0;
						state_q <= ST_HYP;
					end else step_q <= step_q + 4'd1;
				end
				ST_HYP: begin
					if (step_q >= nsteps - 4'd1 || nsteps == 4'd0) state_q <= ST_DIVP;
					else step_q <= step_q + 4'd1;
				end
				ST_DIVP: state_q <= (hx_q == '0 || ay >= ax) ? ST_OUT : ST_DIV;
				ST_DIV: if (div_done) state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q) out_valid_q <= 1'b1;
					else if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: one CORDIC step per cycle. The hyperbolic pass is entered with
	// step 0 set, and hyp_init_q, set on acceptance and in the linear pass, seeds the first step.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) begin
				x_q <= DW'(weight);
				z_q <= DW'(activation_in);
				y_q <= DW'(bias);
				hyp_init_q <= 1'b1;
			end
			ST_LIN: begin
				if (zpos) begin y_q <= y_q + xs; z_q <= z_q - stp; end
				else begin y_q <= y_q - xs; z_q <= z_q + stp; end
				hyp_init_q <= 1'b1;
			end
			default: ;
		endcase
		if (state_q == ST_HYP) begin
			hyp_init_q <= 1'b0;
		end
		if (state_q == ST_DIVP) begin
			neg_q <= (hx_q[DW-1] != hy_q[DW-1]);
			if (hx_q == '0) res_q <= '0;
			else if (ay >= ax)
				res_q <= (hx_q[DW-1] != hy_q[DW-1]) ? -18'sd65536 : 18'sd65536;
		end
		if (state_q == ST_DIV && div_done)
			res_q <= neg_q ? -{1'b0, div_quot} : {1'b0, div_quot};
	end

	// Hyperbolic pass uses a separate register bank seeded at entry.
	assign hx = hyp_init_q ? X0_FIX : hx_q;
	assign hy = hyp_init_q ? '0 : hy_q;
	assign hz = hyp_init_q ? y_q : hz_q;
	assign hxs = $signed(hx) >>> (step_q + 4'd1);
	assign hys = $signed(hy) >>> (step_q + 4'd1);
	assign hzpos = !hz[DW-1] && (hz != '0);

	always_ff @(posedge clk) begin
		if (state_q == ST_HYP) begin
			if (nsteps == 4'd0) begin
				hx_q <= hx; hy_q <= hy; hz_q <= hz;
			end else if (hzpos) begin
				hx_q <= hx + hys; hy_q <= hy + hxs; hz_q <= hz - tv;
			end else begin
				hx_q <= hx - hys; hy_q <= hy - hxs; hz_q <= hz + tv;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign tanh_out = res_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q));
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tanh_out));
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tanh_out <= 18'sd65536) && (tanh_out >= -18'sd65536));
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall);
endmodule

// ===== bench/cordic_mac_tanh_neuron_checker.sv =====
`timescale 1ns / 100ps

module cordic_mac_tanh_neuron_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] weight,
	input  logic signed [31:0] activation_in,
	input  logic signed [31:0] bias,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [17:0] tanh_out,
	output int                 fail_count,
	output int                 pending
);
	import cmtn_pkg::*;

	localparam int STEP_CAP = 12;

	logic [3:0] step_reg;
	logic [17:0] tanh_q[$];

	function automatic longint fix_const(longint e5);
		return ((e5 << 16) + 50000) / 100000;
	endfunction

	function automatic longint atanh_e5(int k);
		case (k)
			0: return 54900;
			1: return 25500;
			2: return 12500;
			3: return 6200;
			4: return 3100;
			5: return 1500;
			6: return 780;
			7: return 390;
			8: return 190;
			9: return 97;
			10: return 48;
			11: return 24;
			default: return 0;
		endcase
	endfunction

	function automatic logic [17:0] neuron_tanh(longint w, longint a, longint b,
			logic [3:0] steps);
		longint x, y, z, dx, dy, t, q;
		longint unsigned ax, ay;
		int n;
		logic neg;
		n = (steps > STEP_CAP) ? STEP_CAP : steps;
		x = w;
		z = a;
		y = b;
		for (int i = 0; i < n; i++) begin
			dx = x >>> i;
			if (z > 0) begin
				y += dx;
				z -= (longint'(1) << 16) >>> i;
			end else begin
				y -= dx;
				z += (longint'(1) << 16) >>> i;
			end
		end
		z = y;
		x = fix_const(127050);
		y = 0;
		for (int i = 0; i < n; i++) begin
			dy = y >>> (i + 1);
			dx = x >>> (i + 1);
			t = fix_const(atanh_e5(i));
			if (z > 0) begin
				x += dy;
				y += dx;
				z -= t;
			end else begin
				x -= dy;
				y -= dx;
				z += t;
			end
		end
		if (x == 0)
			return '0;
		neg = (x < 0) != (y < 0);
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		if (ay >= ax)
			q = 65536;
		else
			q = longint'((ay << 16) / ax);
		return 18'(neg ? -q : q);
	endfunction

	assign pending = tanh_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_reg <= 4'd12;
			fail_count <= 0;
			tanh_q.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_ITER)
				step_reg <= pwdata[3:0];
			if (in_valid && !in_stall)
				tanh_q.push_back(neuron_tanh(longint'(weight), longint'(activation_in),
					longint'(bias), step_reg));
			if (out_valid && !out_stall) begin
				if (tanh_q.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual %0d", $time,
						tanh_out);
					fail_count <= fail_count + 1;
				end else begin
					if (tanh_out !== tanh_q[0]) begin
						$display("%0t: tanh_out mismatch, expected %0d, actual %0d", $time,
							$signed(tanh_q[0]), tanh_out);
						fail_count <= fail_count + 1;
					end
					tanh_q.pop_front();
				end
			end
		end
	end
endmodule

// ===== bench/cordic_mac_tanh_neuron_test.sv =====
`timescale 1ns / 100ps

module cordic_mac_tanh_neuron_test;
	import cmtn_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] weight = '0, activation_in = '0, bias = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [17:0] tanh_out;
	int fail_count, pending;
	int cycles = 0;
	logic stall_on = 1'b1;

	always #6 clk = ~clk;

	cordic_mac_tanh_neuron DUT (.*);

	cordic_mac_tanh_neuron_checker checker_i (.*);

	// Abort on a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("cordic_mac_tanh_neuron_test failed");
			$finish;
		end
	end

	// Receiver: after each beat, stall for a gap drawn at random when stall_on is set.
	always begin
		int gap;
		gap = stall_on ? $urandom_range(0, 3) : 0;
		out_stall <= (gap != 0);
		repeat (gap) @(posedge clk);
		out_stall <= 1'b0;
		@(posedge clk);
		while (!(out_valid && !out_stall)) @(posedge clk);
	end

	// Write the step count through the register port; block must be idle.
	task automatic write_steps(logic [3:0] n);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_ITER;
		pwdata <= {28'd0, n};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Drain all expected beats, then give the block its latency to settle.
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Send one beat after an idle gap drawn at random; hold payload while stalled.
	task automatic send_beat(logic [31:0] w, logic [31:0] a, logic [31:0] b);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		weight <= w;
		activation_in <= a;
		bias <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Mostly modest Q16.16 values so tanh is not always saturated; some full range.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2 * 262144)) - 262144);
			2: return 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
			default: return 32'($signed($urandom_range(0, 2 * 8192)) - 8192);
		endcase
	endfunction

	initial begin
		logic [31:0] edge_vals[6];
		logic [3:0] step_list[6];
		edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000,
			32'hFFFF_0000};
		step_list = '{4'd0, 4'd1, 4'd15, 4'd7, 4'd13, 4'd12};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, zero z, saturation, at reset step count.
		for (int i = 0; i < 6; i++)
			send_beat(edge_vals[i], edge_vals[(i + 1) % 6], edge_vals[(i + 3) % 6]);
		send_beat(32'h0001_0000, 32'h0, 32'h0);
		send_beat(32'h0000_8000, 32'h0001_0000, 32'h0);
		send_beat(32'h0, 32'h0, 32'h7FFF_FFFF);
		send_beat(32'h0, 32'h0, 32'h8000_0000);
		in_valid <= 1'b0;
		drain();

		// Zero step count, above-cap counts, and mid settings.
		for (int p = 0; p < 6; p++) begin
			write_steps(step_list[p]);
			send_beat(edge_vals[p], edge_vals[5 - p], 32'h0000_4000);
			send_beat(32'h0002_0000, 32'h0000_8000, 32'hFFFF_C000);
			in_valid <= 1'b0;
			drain();
		end

		// Random phases, each at a fresh step count.
		for (int p = 0; p < 10; p++) begin
			write_steps(p == 9 ? 4'd12 : 4'($urandom_range(0, 15)));
			stall_on <= (p % 3 != 1);
			for (int k = 0; k < 125; k++)
				send_beat(pick_value(), pick_value(), pick_value());
			in_valid <= 1'b0;
			drain();
		end

		if (fail_count == 0)
			$display("cordic_mac_tanh_neuron_test passed");
		else
			$display("cordic_mac_tanh_neuron_test failed");
		$finish;
	end
endmodule
